// ----- design/preemptive_priority_job_scheduler_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the priority job scheduler
// Enabled unless NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_JOB_SCHEDULER_TOP_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_JOB_SCHEDULER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PPJS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PPJS_ASSERT_NEXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`else
`define PPJS_ASSERT(lbl, prop, msg)
`define PPJS_ASSERT_NEXT(lbl, a, b, msg)
`endif
`endif

// ----- design/ppjs_pkg.sv -----
// ----------------------------------------------------------------------------
// ppjs_pkg
// Types and constants of the priority job scheduler.
// ----------------------------------------------------------------------------
package ppjs_pkg;
	localparam int HEAP_DEPTH_DEF = 31;
	localparam int PRI_LIMIT = 10;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	typedef enum logic [0:0] {
		CMD_ARRIVE = 1'b0,
		CMD_DRAIN  = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		ST_DONE    = 1'b0,
		ST_DROPPED = 1'b1
	} status_t;

	typedef struct packed {
		logic [3:0]  pri;
		logic [15:0] rem;
		logic [31:0] arr;
	} key_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] work;
	} tag_t;

	typedef struct packed {
		key_t key;
		tag_t tag;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_FINISH,
		S_POP_RD,
		S_POP_CMP,
		S_POP_WR,
		S_DECIDE,
		S_PUSH_RD,
		S_PUSH_CMP,
		S_EMIT,
		S_DONE
	} state_t;

	// true when a strictly beats b
	function automatic logic beats(input key_t a, input key_t b);
		logic r;
		if (a.pri != b.pri) begin
			r = a.pri > b.pri;
		end else if (a.rem != b.rem) begin
			r = a.rem < b.rem;
		end else begin
			r = a.arr < b.arr;
		end
		return r;
	endfunction
endpackage

// ----- design/preemptive_priority_job_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// preemptive_priority_job_scheduler_top
// Preemptive priority scheduler with waiting jobs in a binary heap in memory.
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: arrival_time, work, priority_req; tuser: command
// m_axis   out  tdata: job_id .. wait_res; tuser: status; tlast: last
//
// One transaction at a time: tready is high only in the idle state.
// An arrival with nothing to finish passes check, decide, push compare and done
// (decide to done when no job runs), plus push read and compare per level the
// pushed job climbs. Each completion adds finish, then pop read and compare
// when a waiting job is popped, plus pop write and compare per sift-down level.
// A result meeting a full output register holds the sequencer until taken.
// Reset clears control state; heap memory needs no clearing.
// ----------------------------------------------------------------------------
`include "preemptive_priority_job_scheduler_top_defines.svh"
module preemptive_priority_job_scheduler_top #(
	parameter int HEAP_DEPTH = ppjs_pkg::HEAP_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] arrival_time, [47:32] work, [51:48] priority_req
	input  logic [55:0]  s_axis_tdata,
	// [0] command
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [15:0] job_id, [19:16] job_priority, [51:20] end_time,
	// [83:52] turnaround, [115:84] wait_res
	output logic [119:0] m_axis_tdata,
	// [0] status
	output logic         m_axis_tuser,
	output logic         m_axis_tlast
);
	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int PW = CW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

	ppjs_pkg::state_t state_q, state_d;

	ppjs_pkg::entry_t mem [HEAP_DEPTH];
	ppjs_pkg::entry_t rd_a_s1, rd_b_s1;
	logic [AW-1:0]    ra_a, ra_b, wa;
	logic             we;
	ppjs_pkg::entry_t wd;

	logic [31:0]     now_q;
	logic            cur_valid_q;
	ppjs_pkg::entry_t cur_q;
	logic [CW-1:0]   cnt_q;
	logic [15:0]     next_id_q;
	logic            drain_q;
	logic [31:0]     t_q;
	ppjs_pkg::entry_t new_q, mov_q;
	logic [PW-1:0]   idx_q;
	logic            em_pending_q;
	logic            b_ok_q;

	// output register
	logic            ov_q;
	logic [119:0]    od_q;
	logic            ou_q, ol_q;

	logic            out_free;
	assign out_free = !ov_q || m_axis_tready;

	assign s_axis_tready = (state_q == ppjs_pkg::S_IDLE);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = od_q;
	assign m_axis_tuser  = ou_q;
	assign m_axis_tlast  = ol_q;

	// memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a_s1 <= mem[ra_a];
		rd_b_s1 <= mem[ra_b];
	end

	// finish computation
	logic [32:0] end_full;
	logic [31:0] end_t, turn_t, wait_t;
	always_comb begin
		end_full = {1'b0, now_q} + {17'd0, cur_q.key.rem};
		end_t = end_full[32] ? ppjs_pkg::TIME_MAX : end_full[31:0];
		turn_t = end_t - cur_q.key.arr;
		wait_t = (turn_t >= {16'd0, cur_q.tag.work}) ? turn_t - {16'd0, cur_q.tag.work}
			: 32'd0;
	end
	logic finish_due;
	assign finish_due = drain_q || (end_full <= {1'b0, t_q});

	// pop sift-down helpers: p = idx_q, c = 2p+1, c+1
	logic [PW:0] c1, c2;
	assign c1 = {idx_q, 1'b1};
	assign c2 = {idx_q, 1'b0} + (PW+1)'(2);
	logic             b_wins;
	ppjs_pkg::entry_t best;
	logic [PW:0]      best_i;
	always_comb begin
		b_wins = b_ok_q && ppjs_pkg::beats(rd_b_s1.key, rd_a_s1.key);
		best   = b_wins ? rd_b_s1 : rd_a_s1;
		best_i = b_wins ? c2 : c1;
	end

	// push sift-up parent
	logic [PW-1:0] par;
	assign par = (idx_q - PW'(1)) >> 1;

	// decide
	ppjs_pkg::key_t cur_adj;
	always_comb begin
		cur_adj = cur_q.key;
		cur_adj.rem = cur_q.key.rem - 16'(t_q - now_q);
	end

	logic            em_set;
	logic [119:0]    em_d;
	logic            em_u;

	always_comb begin
		state_d = state_q;
		ra_a = '0;
		ra_b = '0;
		we = 1'b0;
		wa = '0;
		wd = mov_q;
		em_set = 1'b0;
		em_d = '0;
		em_u = ppjs_pkg::ST_DONE;
		unique case (state_q)
			ppjs_pkg::S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ppjs_pkg::S_CHECK;
				end
			end
			ppjs_pkg::S_CHECK: begin
				if (cur_valid_q && finish_due) begin
					state_d = ppjs_pkg::S_FINISH;
				end else if (drain_q) begin
					state_d = ppjs_pkg::S_DONE;
				end else begin
					state_d = ppjs_pkg::S_DECIDE;
				end
			end
			ppjs_pkg::S_FINISH: begin
				if (out_free) begin
					em_set = 1'b1;
					em_d = {4'd0, wait_t, turn_t, end_t, cur_q.key.pri, cur_q.tag.id};
					ra_a = '0;
					ra_b = AW'(cnt_q - CW'(1));
					state_d = (cnt_q != '0) ? ppjs_pkg::S_POP_RD : ppjs_pkg::S_CHECK;
				end
			end
			ppjs_pkg::S_POP_RD: begin
				// rd_a = root (new cur), rd_b = tail (moving entry); next read children
				ra_a = AW'(c1);
				ra_b = AW'(c2);
				state_d = ppjs_pkg::S_POP_CMP;
			end
			ppjs_pkg::S_POP_CMP: begin
				if (c1 < {1'b0, PW'(cnt_q)} && !ppjs_pkg::beats(mov_q.key, best.key)) begin
					we = 1'b1;
					wa = AW'(idx_q);
					wd = best;
					state_d = ppjs_pkg::S_POP_WR;
				end else begin
					we = (cnt_q != '0);
					wa = AW'(idx_q);
					wd = mov_q;
					state_d = ppjs_pkg::S_CHECK;
				end
			end
			ppjs_pkg::S_POP_WR: begin
				ra_a = AW'(c1);
				ra_b = AW'(c2);
				state_d = ppjs_pkg::S_POP_CMP;
			end
			ppjs_pkg::S_DECIDE: begin
				if (!cur_valid_q) begin
					state_d = ppjs_pkg::S_DONE;
				end else if (cnt_q >= DEPTH_C) begin
					state_d = ppjs_pkg::S_EMIT;
				end else begin
					ra_a = AW'((PW'(cnt_q) - PW'(1)) >> 1);
					state_d = ppjs_pkg::S_PUSH_CMP;
				end
			end
			ppjs_pkg::S_PUSH_RD: begin
				ra_a = AW'(par);
				state_d = ppjs_pkg::S_PUSH_CMP;
			end
			ppjs_pkg::S_PUSH_CMP: begin
				we = 1'b1;
				wa = AW'(idx_q);
				if (idx_q != '0 && ppjs_pkg::beats(mov_q.key, rd_a_s1.key)) begin
					wd = rd_a_s1;
					state_d = ppjs_pkg::S_PUSH_RD;
				end else begin
					wd = mov_q;
					state_d = ppjs_pkg::S_DONE;
				end
			end
			ppjs_pkg::S_EMIT: begin
				if (out_free) begin
					em_set = 1'b1;
					em_u = ppjs_pkg::ST_DROPPED;
					em_d = {100'd0, mov_q.key.pri, mov_q.tag.id};
					state_d = ppjs_pkg::S_DONE;
				end
			end
			ppjs_pkg::S_DONE: begin
				if (!em_pending_q || out_free) begin
					state_d = ppjs_pkg::S_IDLE;
				end
			end
			default: state_d = ppjs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppjs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// held result: flushed as last when the item ends
	logic [119:0] hd_q;
	logic         hu_q;
	logic         flush;
	assign flush = (state_q == ppjs_pkg::S_DONE) && em_pending_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			em_pending_q <= 1'b0;
		end else begin
			if (em_set) begin
				ov_q <= em_pending_q;
				em_pending_q <= 1'b1;
			end else if (flush) begin
				ov_q <= 1'b1;
				em_pending_q <= 1'b0;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (em_set) begin
			hd_q <= em_d;
			hu_q <= em_u;
			od_q <= hd_q;
			ou_q <= hu_q;
			ol_q <= 1'b0;
		end else if (flush) begin
			od_q <= hd_q;
			ou_q <= hu_q;
			ol_q <= 1'b1;
		end
	end

	// control and job state
	logic [31:0] t_in;
	assign t_in = (s_axis_tdata[31:0] < now_q) ? now_q : s_axis_tdata[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			cur_valid_q <= 1'b0;
			cur_q <= '0;
			cnt_q <= '0;
			next_id_q <= '0;
			drain_q <= 1'b0;
			t_q <= '0;
			new_q <= '0;
			mov_q <= '0;
			idx_q <= '0;
			b_ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				ppjs_pkg::S_IDLE: begin
					if (s_axis_tvalid) begin
						drain_q <= (s_axis_tuser == ppjs_pkg::CMD_DRAIN);
						t_q <= t_in;
						new_q.key <= {s_axis_tdata[51:48], s_axis_tdata[47:32], t_in};
						new_q.tag <= {next_id_q, s_axis_tdata[47:32]};
					end
				end
				ppjs_pkg::S_FINISH: begin
					if (out_free) begin
						now_q <= end_t;
						if (cnt_q == '0) begin
							cur_valid_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - CW'(1);
							idx_q <= '0;
						end
					end
				end
				ppjs_pkg::S_POP_RD: begin
					cur_q <= rd_a_s1;
					mov_q <= rd_b_s1;
					b_ok_q <= c2 < {1'b0, PW'(cnt_q)};
				end
				ppjs_pkg::S_POP_CMP: begin
					idx_q <= PW'(best_i);
				end
				ppjs_pkg::S_POP_WR: begin
					b_ok_q <= c2 < {1'b0, PW'(cnt_q)};
				end
				ppjs_pkg::S_DECIDE: begin
					next_id_q <= next_id_q + 16'd1;
					now_q <= t_q;
					if (!cur_valid_q) begin
						cur_q <= new_q;
						cur_valid_q <= 1'b1;
					end else begin
						if (ppjs_pkg::beats(cur_adj, new_q.key)) begin
							mov_q <= new_q;
							cur_q.key <= cur_adj;
						end else begin
							mov_q <= {cur_adj, cur_q.tag};
							cur_q <= new_q;
						end
						if (cnt_q < DEPTH_C) begin
							idx_q <= PW'(cnt_q);
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ppjs_pkg::S_PUSH_CMP: begin
					if (idx_q != '0 && ppjs_pkg::beats(mov_q.key, rd_a_s1.key)) begin
						idx_q <= par;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`PPJS_ASSERT(a_cnt_bound, (cnt_q <= DEPTH_C), "heap count exceeds depth")
	`PPJS_ASSERT_NEXT(a_hold_out, (ov_q && !m_axis_tready), (ov_q && $stable(od_q)),
		"result changed under stall")
	`PPJS_ASSERT(a_heap_empty_idle, (!cur_valid_q |-> cnt_q == '0 || state_q != ppjs_pkg::S_IDLE),
		"waiting jobs with none running")
	`PPJS_ASSERT(a_idle_clear, (s_axis_tready |-> !em_pending_q), "result held while idle")
endmodule

// ----- tb/tb_ppjs_checker.sv -----
// ----------------------------------------------------------------------------
// Scheduler result checker
// Watches both stream channels, models the preemptive priority scheduler on
// every accepted arrival or drain, and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_ppjs_checker #(
	parameter int DEPTH = ppjs_pkg::HEAP_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [55:0]  s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [119:0] m_axis_tdata,
	input  logic         m_axis_tuser,
	input  logic         m_axis_tlast,
	output int           errors,
	output int           pending
);
	typedef struct packed {
		logic [15:0]       id;
		logic [3:0]        pri;
		logic [31:0]       fin;
		logic [31:0]       turn;
		logic [31:0]       waited;
		ppjs_pkg::status_t st;
		logic              lst;
	} job_result_t;

	job_result_t done_q[$];

	logic [31:0]    sim_now;
	logic           run_valid;
	ppjs_pkg::key_t run_key;
	ppjs_pkg::tag_t run_tag;
	ppjs_pkg::key_t wait_key[DEPTH];
	ppjs_pkg::tag_t wait_tag[DEPTH];
	int             wait_cnt;
	logic [15:0]    id_next;

	function automatic logic outranks(input ppjs_pkg::key_t a, input ppjs_pkg::key_t b);
		if (a.pri != b.pri) return a.pri > b.pri;
		if (a.rem != b.rem) return a.rem < b.rem;
		return a.arr < b.arr;
	endfunction

	task automatic mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
		errors++;
	endtask

	task automatic post_result(input ppjs_pkg::key_t k, input ppjs_pkg::tag_t g,
		input logic [31:0] fin, input logic [31:0] turn, input logic [31:0] waited,
		input ppjs_pkg::status_t st);
		job_result_t r;
		r.id = g.id;
		r.pri = k.pri;
		r.fin = fin;
		r.turn = turn;
		r.waited = waited;
		r.st = st;
		r.lst = 1'b0;
		done_q.push_back(r);
	endtask

	task automatic queue_job(input ppjs_pkg::key_t k, input ppjs_pkg::tag_t g,
		output logic ok);
		int i;
		ok = 1'b0;
		if (wait_cnt >= DEPTH) return;
		ok = 1'b1;
		i = wait_cnt;
		wait_cnt++;
		while (i > 0 && outranks(k, wait_key[(i - 1) / 2])) begin
			wait_key[i] = wait_key[(i - 1) / 2];
			wait_tag[i] = wait_tag[(i - 1) / 2];
			i = (i - 1) / 2;
		end
		wait_key[i] = k;
		wait_tag[i] = g;
	endtask

	task automatic take_best();
		int p;
		int c;
		ppjs_pkg::key_t tk;
		ppjs_pkg::tag_t tt;
		p = 0;
		c = 1;
		run_key = wait_key[0];
		run_tag = wait_tag[0];
		wait_cnt--;
		tk = wait_key[wait_cnt];
		tt = wait_tag[wait_cnt];
		while (c < wait_cnt) begin
			if (c + 1 < wait_cnt && outranks(wait_key[c + 1], wait_key[c])) c++;
			if (outranks(tk, wait_key[c])) break;
			wait_key[p] = wait_key[c];
			wait_tag[p] = wait_tag[c];
			p = c;
			c = 2 * c + 1;
		end
		wait_key[p] = tk;
		wait_tag[p] = tt;
	endtask

	task automatic retire_running();
		logic [32:0] fin;
		logic [31:0] turn;
		fin = {1'b0, sim_now} + 33'(run_key.rem);
		if (fin > {1'b0, ppjs_pkg::TIME_MAX}) fin = {1'b0, ppjs_pkg::TIME_MAX};
		sim_now = fin[31:0];
		turn = fin[31:0] - run_key.arr;
		post_result(run_key, run_tag, fin[31:0], turn,
			(turn >= 32'(run_tag.work)) ? turn - 32'(run_tag.work) : 32'd0,
			ppjs_pkg::ST_DONE);
		if (wait_cnt > 0) take_best();
		else run_valid = 1'b0;
	endtask

	task automatic schedule(input ppjs_pkg::cmd_t cmd, input logic [55:0] d);
		logic [31:0] t;
		logic [15:0] w;
		logic [3:0] p;
		ppjs_pkg::key_t nk;
		ppjs_pkg::tag_t nt;
		ppjs_pkg::key_t lk;
		ppjs_pkg::tag_t lt;
		logic ok;
		int n0;
		n0 = done_q.size();
		t = d[31:0];
		w = d[47:32];
		p = d[51:48];
		if (cmd == ppjs_pkg::CMD_DRAIN) begin
			while (run_valid) retire_running();
		end else begin
			if (t < sim_now) t = sim_now;
			while (run_valid && {1'b0, sim_now} + 33'(run_key.rem) <= {1'b0, t})
				retire_running();
			nk = '{pri: p, rem: w, arr: t};
			nt = '{id: id_next, work: w};
			id_next++;
			if (!run_valid) begin
				run_key = nk;
				run_tag = nt;
				run_valid = 1'b1;
			end else begin
				run_key.rem = run_key.rem - 16'(t - sim_now);
				if (outranks(run_key, nk)) begin
					lk = nk;
					lt = nt;
				end else begin
					lk = run_key;
					lt = run_tag;
					run_key = nk;
					run_tag = nt;
				end
				queue_job(lk, lt, ok);
				if (!ok) post_result(lk, lt, 32'd0, 32'd0, 32'd0, ppjs_pkg::ST_DROPPED);
			end
			sim_now = t;
		end
		if (done_q.size() > n0) done_q[done_q.size() - 1].lst = 1'b1;
	endtask

	task automatic compare_result();
		job_result_t e;
		if (done_q.size() == 0) begin
			mismatch("unexpected result job_id", 32'd0, 32'(m_axis_tdata[15:0]));
			return;
		end
		e = done_q.pop_front();
		if (m_axis_tdata[15:0] != e.id)
			mismatch("job_id", 32'(e.id), 32'(m_axis_tdata[15:0]));
		if (m_axis_tdata[19:16] != e.pri)
			mismatch("job_priority", 32'(e.pri), 32'(m_axis_tdata[19:16]));
		if (m_axis_tdata[51:20] != e.fin) mismatch("end_time", e.fin, m_axis_tdata[51:20]);
		if (m_axis_tdata[83:52] != e.turn) mismatch("turnaround", e.turn, m_axis_tdata[83:52]);
		if (m_axis_tdata[115:84] != e.waited)
			mismatch("wait_res", e.waited, m_axis_tdata[115:84]);
		if (m_axis_tuser != e.st) mismatch("status", 32'(e.st), 32'(m_axis_tuser));
		if (m_axis_tlast != e.lst) mismatch("last", 32'(e.lst), 32'(m_axis_tlast));
	endtask

	initial begin
		errors = 0;
		pending = 0;
		sim_now = '0;
		run_valid = 1'b0;
		run_key = '0;
		run_tag = '0;
		wait_cnt = 0;
		id_next = '0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) compare_result();
			if (s_axis_tvalid && s_axis_tready)
				schedule(ppjs_pkg::cmd_t'(s_axis_tuser), s_axis_tdata);
			pending = done_q.size();
		end
	end
endmodule

// ----- tb/tb_preemptive_priority_job_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// Priority job scheduler testbench
// Drives directed and random job arrivals and drains under varying stream
// back-pressure, with a long output hold-off to fill the heap, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_preemptive_priority_job_scheduler_top;
	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [55:0]  s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [119:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;

	int          errors;
	int          pending;
	int          tx_idle_pct;
	int          rx_idle_pct;
	logic        hold_go;
	logic        hold_on;
	logic [31:0] job_clock;

	preemptive_priority_job_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	tb_ppjs_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.errors(errors),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= !hold_on && ($urandom_range(99) >= rx_idle_pct);
	end

	// hold the receiver off for a long stretch on request
	initial begin
		hold_on = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (600) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_job(input ppjs_pkg::cmd_t cmd, input logic [31:0] t,
		input logic [15:0] w, input logic [3:0] p);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'b0000, p, w, t};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic arrive(input logic [31:0] t, input logic [15:0] w, input logic [3:0] p);
		send_job(ppjs_pkg::CMD_ARRIVE, t, w, p);
	endtask

	task automatic random_jobs(input int count);
		int k;
		int sel;
		logic [15:0] w;
		logic [3:0] p;
		logic [31:0] t;
		for (k = 0; k < count; k++) begin
			sel = $urandom_range(99);
			w = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
			p = ($urandom_range(7) == 0) ? 4'($urandom)
				: 4'($urandom_range(1, ppjs_pkg::PRI_LIMIT));
			if (sel < 6) begin
				send_job(ppjs_pkg::CMD_DRAIN, $urandom, 16'($urandom), 4'($urandom));
			end else if (sel < 14) begin
				t = job_clock - $urandom_range(0, 50);
				arrive(t, w, p);
			end else begin
				job_clock = job_clock + ((sel < 40) ? 32'd0 : $urandom_range(0, 150));
				arrive(job_clock, w, p);
			end
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		hold_go = 1'b0;
		tx_idle_pct = 26;
		rx_idle_pct = 77;
		job_clock = 32'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_job(ppjs_pkg::CMD_DRAIN, 32'd0, 16'd0, 4'd0);
		arrive(32'd0, 16'd1, 4'd1);
		arrive(32'd0, 16'hFFFF, 4'hF);
		arrive(32'd5, 16'd0, 4'd0);
		arrive(32'd3, 16'd10, 4'd10);
		send_job(ppjs_pkg::CMD_DRAIN, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
		arrive(32'h0002_0000, 16'd10, 4'd5);
		arrive(32'h0002_000A, 16'd7, 4'd5);
		arrive(32'h0002_0010, 16'd5, 4'd5);
		arrive(32'h0002_0010, 16'd5, 4'd5);
		arrive(32'h0002_0011, 16'd4, 4'd6);
		arrive(32'h0002_0012, 16'd40, 4'd2);
		arrive(32'h0002_0100, 16'd3, 4'd1);
		send_job(ppjs_pkg::CMD_DRAIN, 32'd0, 16'd0, 4'd0);
		job_clock = 32'h0003_0000;

		random_jobs(140);
		send_job(ppjs_pkg::CMD_DRAIN, 32'd0, 16'd0, 4'd0);
		settle();

		tx_idle_pct = 77;
		rx_idle_pct = 26;
		random_jobs(140);

		// fill the heap while the output is held off
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_go = 1'b1;
		job_clock = job_clock + 32'd500;
		for (k = 0; k < 40; k++)
			arrive(job_clock, 16'($urandom_range(1, 400)),
				4'($urandom_range(1, ppjs_pkg::PRI_LIMIT)));
		arrive(job_clock + 32'd1, 16'd1, 4'hF);
		send_job(ppjs_pkg::CMD_DRAIN, 32'd0, 16'd0, 4'd0);

		random_jobs(140);

		arrive(32'hFFFF_FFF0, 16'hFFFF, 4'd3);
		arrive(32'hFFFF_FFFF, 16'd2, 4'd9);
		arrive(32'hFFFF_FFFF, 16'd8, 4'd9);
		send_job(ppjs_pkg::CMD_DRAIN, 32'd0, 16'd0, 4'd0);

		settle();
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+design
design/ppjs_pkg.sv
design/preemptive_priority_job_scheduler_top.sv
tb/tb_ppjs_checker.sv
tb/tb_preemptive_priority_job_scheduler_top.sv
